@@ hdl/pnf_pkg.sv @@
// Shared types and constants of the parallel NOR flash command device.
package pnf_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TICK_W = 24;

  // Bus item codes
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TICKS  = 2'd3;

  localparam logic [14:0] UNLOCK_ADDR1 = 15'h5555;
  localparam logic [14:0] UNLOCK_ADDR2 = 15'h2AAA;
  localparam logic [DATA_W-1:0] UNLOCK_DATA1   = 8'hAA;
  localparam logic [DATA_W-1:0] UNLOCK_DATA2   = 8'h55;
  localparam logic [DATA_W-1:0] OP_ID          = 8'h90;
  localparam logic [DATA_W-1:0] OP_READ        = 8'hF0;
  localparam logic [DATA_W-1:0] OP_PROGRAM     = 8'hA0;
  localparam logic [DATA_W-1:0] OP_ERASE_SETUP = 8'h80;
  localparam logic [DATA_W-1:0] OP_SECTOR      = 8'h30;
  localparam logic [DATA_W-1:0] OP_BLOCK       = 8'h50;
  localparam logic [DATA_W-1:0] MAKER_ID       = 8'hBF;
  localparam logic [DATA_W-1:0] ERASED_BYTE    = 8'hFF;

  localparam logic [DATA_W-1:0] RESET_DEVICE_CODE  = 8'hD7;
  localparam logic [15:0]       RESET_PROGRAM_TICKS = 16'd20;
  localparam logic [TICK_W-1:0] RESET_SECTOR_TICKS = 24'd25000;
  localparam logic [TICK_W-1:0] RESET_BLOCK_TICKS  = 24'd25000;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_AA,
    SEQ_AA55,
    SEQ_ERS,
    SEQ_ERS_AA,
    SEQ_ERS_AA55,
    SEQ_PROG
  } seq_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_PROG
  } state_t;

endpackage

@@ hdl/pnf_ifs.sv @@
// Valid/ready channel interfaces for bus items and result beats.
interface pnf_in_if;
  logic                         valid;
  logic                         ready;
  logic [pnf_pkg::CMD_W-1:0]    cmd;
  logic [pnf_pkg::ADDR_W-1:0]   address;
  logic [pnf_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output cmd, output address, output write_data, input ready);
  modport sink (input valid, input cmd, input address, input write_data, output ready);
endinterface

interface pnf_out_if;
  logic                         valid;
  logic                         ready;
  logic [pnf_pkg::DATA_W-1:0]   read_data;
  logic                         busy_res;

  modport source (output valid, output read_data, output busy_res, input ready);
  modport sink (input valid, input read_data, input busy_res, output ready);
endinterface

@@ hdl/parallel_nor_flash_command_device.sv @@
// Top level of the parallel NOR flash command device: command FSM around the array memory.
// Results are registered; an array read passes through ST_READ and a byte program through ST_PROG,
// and the input is held there. An erase holds it longer, while the array write port sweeps the
// SECTOR_BYTES or BLOCK_BYTES region (clipped to 2**ADDR_BITS) to FF.
// A result held off by the receiver holds the input; a new beat is taken as the waiting one leaves.
// After reset a clearing pass over the whole array precedes the first beat; cfg writes any time.
module parallel_nor_flash_command_device_core #(
  parameter int unsigned ADDR_BITS    = 16,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned BLOCK_BYTES  = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pnf_in_if.sink                             in_bus,
  pnf_out_if.source                          out_bus,
  input  logic                               cfg_we,
  input  logic [pnf_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [pnf_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam longint unsigned ARRAY_BYTES = 64'd1 << ADDR_BITS;
  localparam longint unsigned SEC_SPAN =
    (SECTOR_BYTES < ARRAY_BYTES) ? SECTOR_BYTES : ARRAY_BYTES;
  localparam longint unsigned BLK_SPAN =
    (BLOCK_BYTES < ARRAY_BYTES) ? BLOCK_BYTES : ARRAY_BYTES;
  localparam logic [ADDR_BITS-1:0] SEC_MASK = ADDR_BITS'(SEC_SPAN - 1);
  localparam logic [ADDR_BITS-1:0] BLK_MASK = ADDR_BITS'(BLK_SPAN - 1);
  localparam logic [ADDR_BITS-1:0] ALL_MASK = '1;

  logic [pnf_pkg::DATA_W-1:0] mem [ARRAY_BYTES];
  logic [pnf_pkg::DATA_W-1:0] mem_rdata_r;
  logic                       mem_we;
  logic [ADDR_BITS-1:0]       mem_waddr;
  logic [pnf_pkg::DATA_W-1:0] mem_wdata;

  pnf_pkg::state_t state_r, state_nxt;
  pnf_pkg::seq_t   seq_r, seq_nxt;
  logic                       id_mode_r, id_mode_nxt;
  logic [pnf_pkg::TICK_W-1:0] busy_r, busy_nxt;
  logic                       toggle_r, toggle_nxt;
  logic                       pb7_r, pb7_nxt;
  logic [ADDR_BITS-1:0]       swp_addr_r, swp_addr_nxt;
  logic [ADDR_BITS-1:0]       swp_mask_r, swp_mask_nxt;
  logic [ADDR_BITS-1:0]       prog_addr_r, prog_addr_nxt;
  logic [pnf_pkg::DATA_W-1:0] prog_data_r, prog_data_nxt;
  logic                       out_vld_r, out_vld_nxt;
  logic [pnf_pkg::DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic                       out_busy_r, out_busy_nxt;

  logic [pnf_pkg::DATA_W-1:0] dev_code_r;
  logic [15:0]                prog_ticks_r;
  logic [pnf_pkg::TICK_W-1:0] sec_ticks_r;
  logic [pnf_pkg::TICK_W-1:0] blk_ticks_r;

  logic                       in_ready;
  logic                       accept;
  logic [ADDR_BITS-1:0]       aidx;
  logic                       at1, at2;
  logic                       wr_ok;
  logic [pnf_pkg::DATA_W-1:0] wd;

  // A zero tick count still keeps the device busy for one tick.
  function automatic logic [pnf_pkg::TICK_W-1:0] load_ticks(
    input logic [pnf_pkg::TICK_W-1:0] t
  );
    return (t == '0) ? pnf_pkg::TICK_W'(1) : t;
  endfunction

  assign aidx = ADDR_BITS'(in_bus.address);
  assign at1  = (in_bus.address[14:0] == pnf_pkg::UNLOCK_ADDR1);
  assign at2  = (in_bus.address[14:0] == pnf_pkg::UNLOCK_ADDR2);
  assign wd   = in_bus.write_data;

  assign in_ready = (state_r == pnf_pkg::ST_IDLE) && (!out_vld_r || out_bus.ready);
  assign accept   = in_bus.valid && in_ready;

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_vld_r;
  assign out_bus.read_data = out_rd_r;
  assign out_bus.busy_res  = out_busy_r;

  // Array memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata_r <= mem[aidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_code_r   <= pnf_pkg::RESET_DEVICE_CODE;
      prog_ticks_r <= pnf_pkg::RESET_PROGRAM_TICKS;
      sec_ticks_r  <= pnf_pkg::RESET_SECTOR_TICKS;
      blk_ticks_r  <= pnf_pkg::RESET_BLOCK_TICKS;
    end else if (cfg_we) begin
      case (cfg_idx)
        pnf_pkg::REG_DEVICE_CODE:   dev_code_r   <= cfg_wdata[7:0];
        pnf_pkg::REG_PROGRAM_TICKS: prog_ticks_r <= cfg_wdata[15:0];
        pnf_pkg::REG_SECTOR_TICKS:  sec_ticks_r  <= cfg_wdata;
        pnf_pkg::REG_BLOCK_TICKS:   blk_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pnf_pkg::ST_SWEEP;
      seq_r      <= pnf_pkg::SEQ_IDLE;
      id_mode_r  <= 1'b0;
      busy_r     <= '0;
      toggle_r   <= 1'b0;
      pb7_r      <= 1'b0;
      swp_addr_r <= '0;
      swp_mask_r <= ALL_MASK;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seq_r      <= seq_nxt;
      id_mode_r  <= id_mode_nxt;
      busy_r     <= busy_nxt;
      toggle_r   <= toggle_nxt;
      pb7_r      <= pb7_nxt;
      swp_addr_r <= swp_addr_nxt;
      swp_mask_r <= swp_mask_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prog_addr_r <= prog_addr_nxt;
    prog_data_r <= prog_data_nxt;
    out_rd_r    <= out_rd_nxt;
    out_busy_r  <= out_busy_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    id_mode_nxt   = id_mode_r;
    busy_nxt      = busy_r;
    toggle_nxt    = toggle_r;
    pb7_nxt       = pb7_r;
    swp_addr_nxt  = swp_addr_r;
    swp_mask_nxt  = swp_mask_r;
    prog_addr_nxt = prog_addr_r;
    prog_data_nxt = prog_data_r;
    out_vld_nxt   = out_vld_r;
    out_rd_nxt    = out_rd_r;
    out_busy_nxt  = out_busy_r;
    mem_we        = 1'b0;
    mem_waddr     = swp_addr_r;
    mem_wdata     = pnf_pkg::ERASED_BYTE;
    wr_ok         = 1'b0;

    // drop the beat once taken
    if (out_vld_r && out_bus.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      pnf_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
        if ((swp_addr_r & swp_mask_r) == swp_mask_r) begin
          state_nxt = pnf_pkg::ST_IDLE;
        end else begin
          swp_addr_nxt = swp_addr_r + 1'b1;
        end
      end

      pnf_pkg::ST_READ: begin
        out_vld_nxt  = 1'b1;
        out_rd_nxt   = mem_rdata_r;
        out_busy_nxt = 1'b0;
        state_nxt    = pnf_pkg::ST_IDLE;
      end

      pnf_pkg::ST_PROG: begin
        mem_we    = 1'b1;
        mem_waddr = prog_addr_r;
        mem_wdata = mem_rdata_r & prog_data_r;
        state_nxt = pnf_pkg::ST_IDLE;
      end

      pnf_pkg::ST_IDLE: begin
        if (accept) begin
          out_vld_nxt = 1'b1;
          out_rd_nxt  = '0;
          case (in_bus.cmd)
            pnf_pkg::CMD_READ: begin
              if (busy_r != '0) begin
                out_rd_nxt = {~pb7_r, toggle_r, 6'b0};
                toggle_nxt = ~toggle_r;
              end else if (id_mode_r) begin
                out_rd_nxt = in_bus.address[0] ? dev_code_r : pnf_pkg::MAKER_ID;
              end else begin
                // array byte arrives from the memory next cycle
                out_vld_nxt = 1'b0;
                state_nxt   = pnf_pkg::ST_READ;
              end
            end

            pnf_pkg::CMD_WRITE: begin
              if (busy_r != '0) begin
                seq_nxt = pnf_pkg::SEQ_IDLE;
              end else begin
                seq_nxt = pnf_pkg::SEQ_IDLE;
                case (seq_r)
                  pnf_pkg::SEQ_IDLE: begin
                    if (at1 && wd == pnf_pkg::UNLOCK_DATA1) begin
                      seq_nxt = pnf_pkg::SEQ_AA;
                      wr_ok   = 1'b1;
                    end else if (wd == pnf_pkg::OP_READ) begin
                      id_mode_nxt = 1'b0;
                      wr_ok       = 1'b1;
                    end
                  end
                  pnf_pkg::SEQ_AA: begin
                    if (at2 && wd == pnf_pkg::UNLOCK_DATA2) begin
                      seq_nxt = pnf_pkg::SEQ_AA55;
                      wr_ok   = 1'b1;
                    end
                  end
                  pnf_pkg::SEQ_AA55: begin
                    if (at1) begin
                      case (wd)
                        pnf_pkg::OP_ID: begin
                          id_mode_nxt = 1'b1;
                          wr_ok       = 1'b1;
                        end
                        pnf_pkg::OP_READ: begin
                          id_mode_nxt = 1'b0;
                          wr_ok       = 1'b1;
                        end
                        pnf_pkg::OP_PROGRAM: begin
                          seq_nxt = pnf_pkg::SEQ_PROG;
                          wr_ok   = 1'b1;
                        end
                        pnf_pkg::OP_ERASE_SETUP: begin
                          seq_nxt = pnf_pkg::SEQ_ERS;
                          wr_ok   = 1'b1;
                        end
                        default: ;
                      endcase
                    end
                  end
                  pnf_pkg::SEQ_ERS: begin
                    if (at1 && wd == pnf_pkg::UNLOCK_DATA1) begin
                      seq_nxt = pnf_pkg::SEQ_ERS_AA;
                      wr_ok   = 1'b1;
                    end
                  end
                  pnf_pkg::SEQ_ERS_AA: begin
                    if (at2 && wd == pnf_pkg::UNLOCK_DATA2) begin
                      seq_nxt = pnf_pkg::SEQ_ERS_AA55;
                      wr_ok   = 1'b1;
                    end
                  end
                  pnf_pkg::SEQ_ERS_AA55: begin
                    if (wd == pnf_pkg::OP_SECTOR) begin
                      busy_nxt     = load_ticks(sec_ticks_r);
                      pb7_nxt      = 1'b1;
                      swp_mask_nxt = SEC_MASK;
                      swp_addr_nxt = aidx & ~SEC_MASK;
                      state_nxt    = pnf_pkg::ST_SWEEP;
                      wr_ok        = 1'b1;
                    end else if (wd == pnf_pkg::OP_BLOCK) begin
                      busy_nxt     = load_ticks(blk_ticks_r);
                      pb7_nxt      = 1'b1;
                      swp_mask_nxt = BLK_MASK;
                      swp_addr_nxt = aidx & ~BLK_MASK;
                      state_nxt    = pnf_pkg::ST_SWEEP;
                      wr_ok        = 1'b1;
                    end
                  end
                  pnf_pkg::SEQ_PROG: begin
                    // read the old byte now, AND and write it back next cycle
                    busy_nxt      = load_ticks(pnf_pkg::TICK_W'(prog_ticks_r));
                    pb7_nxt       = wd[7];
                    prog_addr_nxt = aidx;
                    prog_data_nxt = wd;
                    state_nxt     = pnf_pkg::ST_PROG;
                    wr_ok         = 1'b1;
                  end
                  default: ;
                endcase
                // a stray AA at the first unlock address restarts the sequence
                if (!wr_ok && at1 && wd == pnf_pkg::UNLOCK_DATA1) begin
                  seq_nxt = pnf_pkg::SEQ_AA;
                end
              end
            end

            pnf_pkg::CMD_TICK: begin
              if (busy_r != '0) begin
                busy_nxt = busy_r - 1'b1;
              end
            end

            default: ;
          endcase
          out_busy_nxt = (busy_nxt != '0);
        end
      end

      default: state_nxt = pnf_pkg::ST_IDLE;
    endcase
  end

endmodule
